// File: rtl/task_dependency_tracker_macros.svh
// Assertion macros for the task dependency tracker RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef TASK_DEPENDENCY_TRACKER_MACROS_SVH
`define TASK_DEPENDENCY_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tdt_pkg.sv
// Package for the task dependency tracker: sizes, codes, payload and
// controller/datapath interface structs. No dependencies.
package tdt_pkg;

  // Sizing
  localparam int NUM_TASKS      = 64;
  localparam int MAX_SUCCESSORS = 16;
  localparam int RESULT_LIMIT   = 16;
  localparam int LIST_CAP       = (MAX_SUCCESSORS < RESULT_LIMIT) ?
                                  MAX_SUCCESSORS : RESULT_LIMIT;
  localparam int TID_W   = 6;
  localparam int PCNT_W  = 6;
  localparam int CNT_W   = $clog2(LIST_CAP + 1);
  localparam int IDX_W   = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
  localparam int TASK_AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int LIST_AW = TASK_AW + IDX_W;
  localparam int LIST_DEPTH = NUM_TASKS << IDX_W;
  localparam logic [PCNT_W-1:0] COUNT_MAX = PCNT_W'(63);

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DONE   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result status codes
  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_SELF  = 3'd1;
  localparam logic [2:0] STS_DUP   = 3'd2;
  localparam logic [2:0] STS_FULL  = 3'd3;
  localparam logic [2:0] STS_UNDER = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DECODE,
    S_SCAN,
    S_ADD_END,
    S_WALK,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [TID_W-1:0] task_req;
    logic [TID_W-1:0] other_task;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0]  task_id;
    logic              ready_res;
    logic [PCNT_W-1:0] count;
    logic              has_task;
    logic [2:0]        status;
    logic              is_last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the request
    logic do_clear;    // clear task and report
    logic do_empty;    // report completion with no successors
    logic do_self;     // report ignored self edge
    logic latch_hdr;   // capture list length and count, reset walk index
    logic scan_issue;  // read next list entry for duplicate search
    logic walk_issue;  // read next list entry for completion walk
    logic add_end;     // finish add edge and report
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic       req_ok;
    logic [1:0] cmd;
    logic       self_edge;
    logic       n_zero;
    logic       idx_last;
    logic       walk_done;
  } stat_t;

  // Task id to memory address (zero-extend or truncate to TASK_AW)
  function automatic logic [TASK_AW-1:0] task_addr(logic [TID_W-1:0] id);
    logic [TASK_AW+TID_W-1:0] w;
    w = {{TASK_AW{1'b0}}, id};
    return w[TASK_AW-1:0];
  endfunction

endpackage

// File: rtl/tdt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tdt_ctrl.sv
// Sequencing state machine for the task dependency tracker.
// Depends on tdt_pkg.
module tdt_ctrl
  import tdt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_READ;
      end
      S_READ: begin
        if (!stat.req_ok || stat.cmd == CMD_CLEAR) state_next = S_IDLE;
        else state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.cmd == CMD_ADD) begin
          if (stat.self_edge) state_next = S_IDLE;
          else if (stat.n_zero) state_next = S_ADD_END;
          else state_next = S_SCAN;
        end else begin
          if (stat.n_zero) state_next = S_IDLE;
          else state_next = S_WALK;
        end
      end
      S_SCAN: begin
        if (stat.idx_last) state_next = S_ADD_END;
      end
      S_ADD_END: state_next = S_IDLE;
      S_WALK: begin
        if (stat.idx_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.walk_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: ctrl.load = start;
      S_READ: ctrl.do_clear = stat.req_ok && (stat.cmd == CMD_CLEAR);
      S_DECODE: begin
        ctrl.latch_hdr = 1'b1;
        ctrl.do_self   = (stat.cmd == CMD_ADD) && stat.self_edge;
        ctrl.do_empty  = (stat.cmd != CMD_ADD) && stat.n_zero;
      end
      S_SCAN:    ctrl.scan_issue = 1'b1;
      S_ADD_END: ctrl.add_end    = 1'b1;
      S_WALK:    ctrl.walk_issue = 1'b1;
      S_DRAIN:   ;
      default:   ;
    endcase
  end

endmodule

// File: rtl/tdt_dp.sv
// Datapath of the task dependency tracker: count and list memories,
// duplicate search, completion walk pipeline and result register.
// Depends on tdt_pkg, tdt_ram and task_dependency_tracker_macros.svh.
`include "task_dependency_tracker_macros.svh"

module tdt_dp
  import tdt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  req_t  request,
  input  ctrl_t ctrl,
  output stat_t stat,
  output logic  done,
  output res_t  result
);

  req_t req_q;
  logic [CNT_W-1:0]  n_q;
  logic [PCNT_W-1:0] p_q;
  logic [CNT_W-1:0]  idx;
  logic dup_q, scan_v;
  logic lv1, last1, lv2, last2;
  logic [TID_W-1:0] s2;

  logic [TASK_AW-1:0] t_a, o_a;
  assign t_a = task_addr(req_q.task_req);
  assign o_a = task_addr(req_q.other_task);

  // Memories and valid bits
  logic [NUM_TASKS-1:0] pvalid, svalid;
  logic pval_q, sval_q;

  logic              pend_we;
  logic [TASK_AW-1:0] pend_wa, pend_ra;
  logic [PCNT_W-1:0] pend_wd, pend_raw, pend_rd;

  logic              scnt_we;
  logic [CNT_W-1:0]  scnt_wd, scnt_raw, scnt_rd;

  logic              list_we;
  logic [LIST_AW-1:0] list_wa, list_ra;
  logic [TID_W-1:0]  list_rd;

  tdt_ram #(.WIDTH(PCNT_W), .DEPTH(NUM_TASKS)) u_pend (
    .clk(clk), .we(pend_we), .waddr(pend_wa), .wdata(pend_wd),
    .raddr(pend_ra), .rdata(pend_raw)
  );

  tdt_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TASKS)) u_scnt (
    .clk(clk), .we(scnt_we), .waddr(t_a), .wdata(scnt_wd),
    .raddr(t_a), .rdata(scnt_raw)
  );

  tdt_ram #(.WIDTH(TID_W), .DEPTH(LIST_DEPTH)) u_list (
    .clk(clk), .we(list_we), .waddr(list_wa), .wdata(req_q.other_task),
    .raddr(list_ra), .rdata(list_rd)
  );

  // Read addresses; a count or length entry never written since reset reads as zero
  assign pend_ra = lv1 ? task_addr(list_rd) : o_a;
  assign list_ra = {t_a, idx[IDX_W-1:0]};
  assign pend_rd = pval_q ? pend_raw : '0;
  assign scnt_rd = sval_q ? scnt_raw : '0;

  // Duplicate search and add-edge decision
  logic match, dup_f, full, add_ok;
  logic [2:0] add_st;
  assign match  = scan_v && (list_rd == req_q.other_task);
  assign dup_f  = dup_q || match;
  assign full   = (n_q >= CNT_W'(LIST_CAP)) || (p_q == COUNT_MAX);
  assign add_st = dup_f ? STS_DUP : (full ? STS_FULL : STS_OK);
  assign add_ok = ctrl.add_end && (add_st == STS_OK);

  // Completion walk, stage 2
  logic              under;
  logic [PCNT_W-1:0] dec;
  assign under = (pend_rd == '0);
  assign dec   = pend_rd - PCNT_W'(1);

  // Write ports
  always_comb begin
    pend_we = 1'b0;
    pend_wa = t_a;
    pend_wd = '0;
    if (ctrl.do_clear) begin
      pend_we = 1'b1;
    end else if (add_ok) begin
      pend_we = 1'b1;
      pend_wa = o_a;
      pend_wd = p_q + PCNT_W'(1);
    end else if (lv2 && !under) begin
      pend_we = 1'b1;
      pend_wa = task_addr(s2);
      pend_wd = dec;
    end
  end

  assign scnt_we = ctrl.do_clear || add_ok;
  assign scnt_wd = ctrl.do_clear ? '0 : n_q + CNT_W'(1);
  assign list_we = add_ok;
  assign list_wa = {t_a, n_q[IDX_W-1:0]};

  // Status to controller
  always_comb begin
    stat.req_ok = (int'(req_q.task_req) < NUM_TASKS) && (req_q.command != CMD_UNUSED) &&
                  ((req_q.command != CMD_ADD) || (int'(req_q.other_task) < NUM_TASKS));
    stat.cmd       = req_q.command;
    stat.self_edge = (req_q.task_req == req_q.other_task);
    stat.n_zero    = (scnt_rd == '0);
    stat.idx_last  = (idx == n_q - CNT_W'(1));
    stat.walk_done = lv2 && last2;
  end

  // Result selection
  logic emit;
  res_t res_next;
  always_comb begin
    emit     = 1'b1;
    res_next = '0;
    res_next.has_task = 1'b1;
    res_next.is_last  = 1'b1;
    res_next.status   = STS_OK;
    if (ctrl.do_clear) begin
      res_next.task_id = req_q.task_req;
    end else if (ctrl.do_empty) begin
      res_next.has_task = 1'b0;
    end else if (ctrl.do_self) begin
      res_next.task_id = req_q.other_task;
      res_next.count   = pend_rd;
      res_next.status  = STS_SELF;
    end else if (ctrl.add_end) begin
      res_next.task_id = req_q.other_task;
      res_next.count   = add_ok ? p_q + PCNT_W'(1) : p_q;
      res_next.status  = add_st;
    end else if (lv2) begin
      res_next.task_id   = s2;
      res_next.count     = under ? '0 : dec;
      res_next.ready_res = !under && (dec == '0);
      res_next.status    = under ? STS_UNDER : STS_OK;
      res_next.is_last   = last2;
    end else begin
      emit = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
      svalid <= '0;
      scan_v <= 1'b0;
      lv1    <= 1'b0;
      lv2    <= 1'b0;
      dup_q  <= 1'b0;
      done   <= 1'b0;
    end else begin
      if (pend_we) pvalid[pend_wa] <= 1'b1;
      if (scnt_we) svalid[t_a] <= 1'b1;
      scan_v <= ctrl.scan_issue;
      lv1    <= ctrl.walk_issue;
      lv2    <= lv1;
      if (ctrl.latch_hdr) dup_q <= 1'b0;
      else if (match) dup_q <= 1'b1;
      done <= emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctrl.load) req_q <= request;
    pval_q <= pvalid[pend_ra];
    sval_q <= svalid[t_a];
    if (ctrl.latch_hdr) begin
      n_q <= scnt_rd;
      p_q <= pend_rd;
      idx <= '0;
    end else if (ctrl.scan_issue || ctrl.walk_issue) begin
      idx <= idx + CNT_W'(1);
    end
    last1 <= stat.idx_last;
    last2 <= last1;
    s2    <= list_rd;
    if (emit) result <= res_next;
  end

  // Checks
  `TDT_ASSERT_NOW(a_walk_alone, lv2,
    !(ctrl.do_clear || ctrl.do_empty || ctrl.do_self || ctrl.add_end),
    "walk result collides with another result")
  `TDT_ASSERT_NOW(a_scan_nonempty, ctrl.scan_issue || ctrl.walk_issue, n_q != '0,
    "list read issued for an empty list")
  `TDT_ASSERT_NEXT(a_walk_drains, lv2 && last2, !lv1 && !lv2,
    "walk pipeline not empty after last result")
  `TDT_ASSERT_NOW(a_list_room, list_we, n_q < CNT_W'(LIST_CAP),
    "successor list written past its capacity")

endmodule

// File: rtl/task_dependency_tracker.sv
// Task dependency tracker: per-task pending counts and successor lists.
// Command channel: a request (command, task_req, other_task) is taken at a
// rising edge with start high and busy low. busy stays high until the last
// result of the request has been formed; one request is worked at a time.
// Result channel: each result sits on result for one cycle with done high.
// The receiver cannot stall; results must be taken as they come.
// Per command:
//   clear: one result.
//   add edge: one result; the duplicate search reads one list entry a
//   cycle, one per stored successor; a self edge skips the search.
//   complete: one result per successor, one result a cycle from the
//   walk pipeline (list read, count read, count write); with none, one result with no task.
//   Unknown commands and out-of-range ids: no result.
// The walk and the search rate are set by the single read port of the
// successor list memory. Results appear the cycle after they are formed.
// Reset clears all pending counts and list lengths at once through valid
// bits; the block takes requests in the first cycle after reset.
// Depends on tdt_pkg, tdt_ctrl and tdt_dp.
module task_dependency_tracker
  import tdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);

  ctrl_t ctrl;
  stat_t stat;

  tdt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .ctrl(ctrl), .busy(busy)
  );

  tdt_dp u_dp (
    .clk(clk), .rst(rst), .request(request), .ctrl(ctrl), .stat(stat),
    .done(done), .result(result)
  );

endmodule
